[rtl/drm_pkg.sv]
// Package for the drop rate meter: field widths, register indexes,
// register reset values and the result record. No dependencies.
package drm_pkg;

   localparam int GAP_W      = 20;
   localparam int INTERVAL_W = 26;
   localparam int SCALE_W    = 8;
   localparam int RATE_W     = 16;
   localparam int TOTAL_W    = 32;
   localparam int PRODUCT_W  = RATE_W + SCALE_W;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = INTERVAL_W;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_SCALE = 2'd2;

   localparam logic [GAP_W-1:0]      MIN_GAP_RESET    = 20'd50000;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET   = 26'd10000000;
   localparam logic [SCALE_W-1:0]    RATE_SCALE_RESET = 8'd6;

   typedef struct packed {
      logic [RATE_W-1:0]  drops_per_min;
      logic [TOTAL_W-1:0] total_drops;
      logic               drop_accepted;
      logic               rate_updated;
   } rsp_type;

endpackage

[rtl/drop_rate_meter_unit.sv]
// Drop rate meter: hold-off drop counter and windowed drops-per-minute rate.
// Depends on drm_pkg.
// Path: a tick is held in the input register, and its result is held in the result register on rsp_.
// Throughput: one tick per cycle while rsp_stall is low; an input register and a result register
// part the two channels, the single-pass update sits between them.
// Reset (synchronous): counters, held rate and valids clear; registers take
// their default values.
module drop_rate_meter_unit
   import drm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_drop_edge,
   input  logic                  req_rate_request,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [RATE_W-1:0]     rsp_drops_per_min,
   output logic [TOTAL_W-1:0]    rsp_total_drops,
   output logic                  rsp_drop_accepted,
   output logic                  rsp_rate_updated,

   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [GAP_W-1:0]      min_gap_ff;
   logic [INTERVAL_W-1:0] interval_ff;
   logic [SCALE_W-1:0]    rate_scale_ff;

   logic                  in_valid_ff;
   logic                  in_edge_ff;
   logic                  in_request_ff;

   logic [GAP_W-1:0]      since_drop_ff, since_drop_in, since_drop_inc;
   logic [INTERVAL_W-1:0] since_rate_ff, since_rate_in, since_rate_inc;
   logic [RATE_W-1:0]     window_ff, window_in, window_acc;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [RATE_W-1:0]     held_rate_ff, held_rate_in;
   logic [PRODUCT_W-1:0]  product;

   logic                  rsp_valid_ff;
   rsp_type               rsp_ff, rsp_in;

   logic                  accepted, updated;
   logic                  out_free, advance, take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   // elapsed time, saturating
   assign since_drop_inc = (&since_drop_ff) ? since_drop_ff : since_drop_ff + 1'b1;
   assign since_rate_inc = (&since_rate_ff) ? since_rate_ff : since_rate_ff + 1'b1;

   assign accepted   = in_edge_ff && (since_drop_inc >= min_gap_ff);
   assign window_acc = (accepted && !(&window_ff)) ? window_ff + 1'b1 : window_ff;
   assign updated    = in_request_ff && (since_rate_inc >= interval_ff);
   assign product    = window_acc * rate_scale_ff;

   always_comb begin
      since_drop_in = accepted ? '0 : since_drop_inc;
      total_in      = accepted ? total_ff + 1'b1 : total_ff;
      since_rate_in = since_rate_inc;
      window_in     = window_acc;
      held_rate_in  = held_rate_ff;
      if (updated) begin
         since_rate_in = '0;
         window_in     = '0;
         held_rate_in  = (|product[PRODUCT_W-1:RATE_W]) ? '1 : product[RATE_W-1:0];
      end
      rsp_in.drops_per_min = held_rate_in;
      rsp_in.total_drops   = total_in;
      rsp_in.drop_accepted = accepted;
      rsp_in.rate_updated  = updated;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_gap_ff    <= MIN_GAP_RESET;
         interval_ff   <= INTERVAL_RESET;
         rate_scale_ff <= RATE_SCALE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MIN_GAP:    min_gap_ff    <= csr_wdata[GAP_W-1:0];
            CSR_INTERVAL:   interval_ff   <= csr_wdata[INTERVAL_W-1:0];
            CSR_RATE_SCALE: rate_scale_ff <= csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_edge_ff    <= req_drop_edge;
         in_request_ff <= req_rate_request;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         since_drop_ff <= '0;
         since_rate_ff <= '0;
         window_ff     <= '0;
         total_ff      <= '0;
         held_rate_ff  <= '0;
      end else if (advance) begin
         since_drop_ff <= since_drop_in;
         since_rate_ff <= since_rate_in;
         window_ff     <= window_in;
         total_ff      <= total_in;
         held_rate_ff  <= held_rate_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drops_per_min = rsp_ff.drops_per_min;
   assign rsp_total_drops   = rsp_ff.total_drops;
   assign rsp_drop_accepted = rsp_ff.drop_accepted;
   assign rsp_rate_updated  = rsp_ff.rate_updated;

endmodule

[rtl/drm_checker.sv]
// Port-level checker for drop_rate_meter_unit, bound into every drop_rate_meter_unit instance.
// Depends on drm_pkg.
module drm_port_checker
   import drm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [RATE_W-1:0]     rsp_drops_per_min,
   input logic [TOTAL_W-1:0]    rsp_total_drops,
   input logic                  rsp_drop_accepted,
   input logic                  rsp_rate_updated
);

   logic [TOTAL_W-1:0] last_total_ff;
   logic [RATE_W-1:0]  last_rate_ff;
   logic               transfer;

   assign transfer = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_total_ff <= '0;
         last_rate_ff  <= '0;
      end else if (transfer) begin
         last_total_ff <= rsp_total_drops;
         last_rate_ff  <= rsp_drops_per_min;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_total_drops)
         && $stable(rsp_drops_per_min))
      else $error("stalled result changed");

   a_total_step: assert property (@(posedge clock) disable iff (reset)
      transfer |-> rsp_total_drops == last_total_ff + {{(TOTAL_W-1){1'b0}}, rsp_drop_accepted})
      else $error("total does not follow accepted drops");

   a_rate_held: assert property (@(posedge clock) disable iff (reset)
      transfer && !rsp_rate_updated |-> rsp_drops_per_min == last_rate_ff)
      else $error("rate changed without an update");

endmodule

bind drop_rate_meter_unit drm_port_checker u_drm_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_drops_per_min (rsp_drops_per_min),
   .rsp_total_drops   (rsp_total_drops),
   .rsp_drop_accepted (rsp_drop_accepted),
   .rsp_rate_updated  (rsp_rate_updated)
);
